// ===== rtl/core/brlr_pkg.sv =====
`default_nettype none

package brlr_pkg;

  // Entry buffer size, in (keys, duration) entries
  localparam int ENTRY_CAPACITY = 1764;

  localparam int IDX_W  = (ENTRY_CAPACITY > 2) ? $clog2(ENTRY_CAPACITY) : 1;
  localparam int EIDX_W = 11;
  localparam int KEY_W  = 8;
  localparam int DUR_W  = 8;
  localparam int BLEN_W = 12;

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(ENTRY_CAPACITY - 1);
  localparam logic [BLEN_W-1:0] FULL_BYTES = BLEN_W'((2 * ENTRY_CAPACITY) % (1 << BLEN_W));
  localparam logic [DUR_W-1:0]  DUR_MAX    = {DUR_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_RECORDING = 2'd1,
    MODE_FINISHED  = 2'd2
  } mode_t;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_ENTRY    = 1'b0,
    KIND_FINISHED = 1'b1
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [EIDX_W-1:0] entry_index;
    logic [KEY_W-1:0]  entry_keys;
    logic [DUR_W-1:0]  entry_duration;
    logic [BLEN_W-1:0] byte_length;
  } res_t;

  // Zero-extend or truncate the internal index to the output field width
  function automatic logic [EIDX_W-1:0] to_entry_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+EIDX_W-1:0] w;
    w = {{EIDX_W{1'b0}}, idx};
    return w[EIDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/button_run_length_recorder_top.sv =====
`default_nettype none

// Button run-length recorder.
// Input channel (in_valid/in_ready): one word per frame, in_op selects start
// (clear the run, begin recording at entry zero) or a sample of in_buttons.
// Each sample is mapped to an 8-bit key code and folded into the current
// run; every recorded sample returns one word on the output channel
// (out_valid/out_ready) with the updated entry. When a new entry is needed
// and the buffer is full, a finished word carries the byte length and the
// recorder stops until the next start. Start words and samples taken while
// not recording return nothing.
// The result word is registered and appears in the cycle after its input is accepted.
// Throughput: one word per cycle while the output side is not stalled; the run
// state is updated combinationally, so back-to-back samples need no bubbles.
// Stall: a single output register holds the pending word; in_ready stays high
// while that register is empty or being drained in the same cycle.
// Reset (rst_n, synchronous): recorder idle, run cleared, output empty.
module button_run_length_recorder_top
  import brlr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_op,
  input  wire logic [15:0]       in_buttons,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_kind,
  output logic      [EIDX_W-1:0] out_entry_index,
  output logic      [KEY_W-1:0]  out_entry_keys,
  output logic      [DUR_W-1:0]  out_entry_duration,
  output logic      [BLEN_W-1:0] out_byte_length
);

  logic in_fire;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  brlr_run u_run (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_op      (in_op),
    .in_buttons (in_buttons),
    .res        (res)
  );

  // output register: load on a new result word, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = res.valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_entry_index    = out_r.entry_index;
  assign out_entry_keys     = out_r.entry_keys;
  assign out_entry_duration = out_r.entry_duration;
  assign out_byte_length    = out_r.byte_length;

endmodule

`default_nettype wire

// ===== rtl/core/brlr_keymap.sv =====
`default_nettype none

module brlr_keymap
  import brlr_pkg::*;
(
  input  wire logic [15:0]      buttons,
  output logic      [KEY_W-1:0] code
);

  // code bits 0..7 <- buttons 0, 1, 8, (9 | 10), 4, 5, 7, 6
  assign code = {buttons[6], buttons[7], buttons[5], buttons[4],
                 buttons[9] | buttons[10], buttons[8], buttons[1], buttons[0]};

endmodule

`default_nettype wire

// ===== rtl/core/brlr_run.sv =====
`default_nettype none

module brlr_run
  import brlr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire logic        in_op,
  input  wire logic [15:0] in_buttons,
  output res_t             res
);

  mode_t             mode_r, mode_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [KEY_W-1:0]  keys_r, keys_nxt;
  logic [DUR_W-1:0]  len_r, len_nxt;
  logic [KEY_W-1:0]  code;
  logic              open_new;
  logic              full;
  logic              is_start;
  logic              recording;

  brlr_keymap u_keymap (
    .buttons (in_buttons),
    .code    (code)
  );

  assign is_start  = (op_t'(in_op) == OP_START);
  assign recording = (mode_r == MODE_RECORDING);
  assign open_new  = ((len_r != '0) && (keys_r != code)) || (len_r == DUR_MAX);
  assign full      = (idx_r == LAST_IDX);

  // next state
  always_comb begin
    mode_nxt = mode_r;
    if (in_fire) begin
      if (is_start) begin
        mode_nxt = MODE_RECORDING;
      end else if (recording && open_new && full) begin
        mode_nxt = MODE_FINISHED;
      end
    end
  end

  // run registers
  always_comb begin
    idx_nxt  = idx_r;
    keys_nxt = keys_r;
    len_nxt  = len_r;
    if (in_fire) begin
      if (is_start) begin
        idx_nxt  = '0;
        keys_nxt = '0;
        len_nxt  = '0;
      end else if (recording && !(open_new && full)) begin
        keys_nxt = code;
        if (open_new) begin
          idx_nxt = idx_r + IDX_W'(1);
          len_nxt = DUR_W'(1);
        end else begin
          len_nxt = len_r + DUR_W'(1);
        end
      end
    end
  end

  // result word: entry write shows the updated run, finish shows it unchanged
  always_comb begin
    res.valid = in_fire && !is_start && recording;
    if (open_new && full) begin
      res.kind           = KIND_FINISHED;
      res.entry_index    = to_entry_index(idx_r);
      res.entry_keys     = keys_r;
      res.entry_duration = len_r;
      res.byte_length    = FULL_BYTES;
    end else begin
      res.kind           = KIND_ENTRY;
      res.entry_index    = to_entry_index(open_new ? idx_r + IDX_W'(1) : idx_r);
      res.entry_keys     = code;
      res.entry_duration = open_new ? DUR_W'(1) : len_r + DUR_W'(1);
      res.byte_length    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      idx_r  <= '0;
      keys_r <= '0;
      len_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      idx_r  <= idx_nxt;
      keys_r <= keys_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

// Bench for the button run-length recorder.
// A directed table walks the key mapping, starts, idle samples and the two
// extreme button words. A random part follows: recording sessions built of
// key runs, mostly short, a few long enough to roll the duration over, with
// some raw noise words mixed in. A final pass fills the whole entry buffer
// so the finished word comes out, then checks that samples are dropped and
// that a new start revives the recorder.
// Every accepted input word goes through a local model of the recorder. Each
// output word is checked field by field against the oldest pending word.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import brlr_pkg::*;

  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  // one output word as the recorder should present it
  typedef struct packed {
    kind_t             kind;
    logic [EIDX_W-1:0] index;
    logic [KEY_W-1:0]  keys;
    logic [DUR_W-1:0]  duration;
    logic [BLEN_W-1:0] byte_len;
  } entry_word_t;

  // directed step: pinned rows carry the word typed in by hand
  typedef struct packed {
    op_t         op;
    logic [15:0] buttons;
    logic        pinned;
    logic        has_word;
    entry_word_t word;
  } step_row_t;

  localparam entry_word_t NO_WORD = '{KIND_ENTRY, '0, '0, '0, '0};

  localparam step_row_t DIRECTED_STEPS [20] = '{
    // sample right after reset: recorder idle, nothing comes back
    '{OP_SAMPLE, 16'hFFFF, 1'b1, 1'b0, NO_WORD},
    '{OP_START,  16'h0000, 1'b1, 1'b0, NO_WORD},
    // all buttons, then none: first run, its extension, a fresh entry
    '{OP_SAMPLE, 16'hFFFF, 1'b1, 1'b1, '{KIND_ENTRY, 11'd0, 8'hFF, 8'd1, 12'd0}},
    '{OP_SAMPLE, 16'hFFFF, 1'b1, 1'b1, '{KIND_ENTRY, 11'd0, 8'hFF, 8'd2, 12'd0}},
    '{OP_SAMPLE, 16'h0000, 1'b1, 1'b1, '{KIND_ENTRY, 11'd1, 8'h00, 8'd1, 12'd0}},
    // one mapped button at a time; 0x200, 0x400 and 0x600 share code bit 3
    '{OP_SAMPLE, 16'h0001, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0002, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0100, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0200, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0400, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0600, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0010, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0020, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0080, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0040, 1'b0, 1'b0, NO_WORD},
    // unmapped buttons only, so the code is zero
    '{OP_SAMPLE, 16'hF80C, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0000, 1'b0, 1'b0, NO_WORD},
    // restart while recording; buttons of a start word are ignored
    '{OP_START,  16'hFFFF, 1'b1, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'h0008, 1'b0, 1'b0, NO_WORD},
    '{OP_SAMPLE, 16'hFFFF, 1'b0, 1'b0, NO_WORD}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = OP_SAMPLE;
  logic [15:0]       in_buttons = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_kind;
  logic [EIDX_W-1:0] out_entry_index;
  logic [KEY_W-1:0]  out_entry_keys;
  logic [DUR_W-1:0]  out_entry_duration;
  logic [BLEN_W-1:0] out_byte_length;

  // local copy of the recorder state
  mode_t             rec_mode = MODE_IDLE;
  int unsigned       run_at = 0;
  logic [KEY_W-1:0]  run_code = '0;
  logic [DUR_W-1:0]  run_frames = '0;

  entry_word_t       pending_words[$];
  entry_word_t       want_word;
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  bit                quiet = 1'b0;       // both sides run without idling
  bit                drain_first = 1'b0; // sender holds off until all words are back

  button_run_length_recorder_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_buttons         (in_buttons),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_entry_index    (out_entry_index),
    .out_entry_keys     (out_entry_keys),
    .out_entry_duration (out_entry_duration),
    .out_byte_length    (out_byte_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // buttons 0, 1, 8, (9 or 10), 4, 5, 7, 6 land on code bits 0..7
  function automatic logic [KEY_W-1:0] key_code(input logic [15:0] b);
    logic [KEY_W-1:0] k;
    k[0] = b[0];
    k[1] = b[1];
    k[2] = b[8];
    k[3] = b[9] | b[10];
    k[4] = b[4];
    k[5] = b[5];
    k[6] = b[7];
    k[7] = b[6];
    return k;
  endfunction

  // random raw buttons that map to the given code; unmapped bits and the
  // choice between buttons 9 and 10 are free
  function automatic logic [15:0] raw_for_code(input logic [KEY_W-1:0] c);
    logic [15:0] b;
    logic [1:0]  sel;
    b = 16'($urandom) & 16'hF80C;
    sel = 2'($urandom_range(1, 3));
    b[0] = c[0];
    b[1] = c[1];
    b[8] = c[2];
    if (c[3]) begin
      b[9]  = sel[0];
      b[10] = sel[1];
    end
    b[4] = c[4];
    b[5] = c[5];
    b[7] = c[6];
    b[6] = c[7];
    return b;
  endfunction

  // advance the recorder model by one input word
  task automatic fold_word(input op_t op, input logic [15:0] btn,
                           output bit has, output entry_word_t w);
    logic [KEY_W-1:0] code;
    bit               open_entry;
    has = 1'b0;
    w = NO_WORD;
    if (op == OP_START) begin
      rec_mode = MODE_RECORDING;
      run_at = 0;
      run_code = '0;
      run_frames = '0;
    end else if (rec_mode == MODE_RECORDING) begin
      code = key_code(btn);
      open_entry = (run_frames != 0 && run_code != code) || run_frames == DUR_MAX;
      has = 1'b1;
      if (open_entry && run_at + 1 >= ENTRY_CAPACITY) begin
        // buffer full: report the last entry as it stands and stop
        rec_mode = MODE_FINISHED;
        w = '{KIND_FINISHED, EIDX_W'(run_at), run_code, run_frames,
              BLEN_W'(2 * (run_at + 1))};
      end else begin
        if (open_entry) begin
          run_at++;
          run_frames = '0;
        end
        run_code = code;
        run_frames = run_frames + 1'b1;
        w = '{KIND_ENTRY, EIDX_W'(run_at), run_code, run_frames, '0};
      end
    end
  endtask

  // drive one word, wait for the handshake, then log what should come back
  task automatic send_word(input op_t op, input logic [15:0] btn, input logic pinned,
                           input logic pin_has, input entry_word_t pin_word);
    int unsigned gap;
    bit          has;
    entry_word_t w;
    if ($urandom_range(0, 39) == 0)
      quiet = ~quiet;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0 || (drain_first && pending_words.size() != 0)) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain_first && pending_words.size() != 0) @(posedge clk);
    end
    drain_first = 1'b0;
    in_valid   <= 1'b1;
    in_op      <= op;
    in_buttons <= btn;
    do @(posedge clk); while (!(in_valid && in_ready));
    fold_word(op, btn, has, w);
    if (pinned) begin
      has = pin_has;
      w = pin_word;
    end
    if (has)
      pending_words.push_back(w);
  endtask

  // receiver: random stalls, drawn per word
  initial begin
    int unsigned hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // output checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("word with none pending: kind %0d index %0d keys %0h duration %0d",
               out_kind, out_entry_index, out_entry_keys, out_entry_duration);
        fail_count++;
      end else begin
        want_word = pending_words.pop_front();
        if (out_kind !== want_word.kind) begin
          $error("kind: expected %0d, got %0d", want_word.kind, out_kind);
          fail_count++;
        end
        if (out_entry_index !== want_word.index) begin
          $error("entry_index: expected %0d, got %0d", want_word.index, out_entry_index);
          fail_count++;
        end
        if (out_entry_keys !== want_word.keys) begin
          $error("entry_keys: expected %0h, got %0h", want_word.keys, out_entry_keys);
          fail_count++;
        end
        if (out_entry_duration !== want_word.duration) begin
          $error("entry_duration: expected %0d, got %0d",
                 want_word.duration, out_entry_duration);
          fail_count++;
        end
        if (out_byte_length !== want_word.byte_len) begin
          $error("byte_length: expected %0d, got %0d", want_word.byte_len, out_byte_length);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned      sent;
    int unsigned      runs;
    int unsigned      len;
    int unsigned      pick;
    bit               force_long;
    bit               drained;
    logic [KEY_W-1:0] code;
    logic [15:0]      btn;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED_STEPS); i++)
      send_word(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].buttons, DIRECTED_STEPS[i].pinned,
                DIRECTED_STEPS[i].has_word, DIRECTED_STEPS[i].word);

    // random sessions: a start, then runs of one code each; the first run of the
    // first session is long enough to saturate the duration and force a new entry
    sent = 0;
    force_long = 1'b1;
    drained = 1'b0;
    code = '0;
    while (sent < RANDOM_WORDS) begin
      send_word(OP_START, 16'($urandom), 1'b0, 1'b0, NO_WORD);
      sent++;
      runs = $urandom_range(1, 40);
      for (int r = 0; r < runs; r++) begin
        // now and then keep the code so two runs merge
        if ($urandom_range(0, 9) != 0)
          code = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (force_long) begin
          len = $urandom_range(256, 300);
          force_long = 1'b0;
        end else if (pick < 4) begin
          len = $urandom_range(250, 300);
        end else if (pick < 20) begin
          len = $urandom_range(7, 40);
        end else begin
          len = $urandom_range(1, 6);
        end
        for (int k = 0; k < len; k++) begin
          btn = ($urandom_range(0, 9) == 0) ? 16'($urandom) : raw_for_code(code);
          // once, halfway through, let the output side drain completely
          if (!drained && sent >= RANDOM_WORDS / 2) begin
            drain_first = 1'b1;
            drained = 1'b1;
          end
          send_word(OP_SAMPLE, btn, 1'b0, 1'b0, NO_WORD);
          sent++;
        end
      end
    end

    // fill the whole buffer: every run changes the code, so each one takes
    // an entry, until the finished word comes out
    send_word(OP_START, 16'($urandom), 1'b0, 1'b0, NO_WORD);
    code = 8'($urandom);
    while (rec_mode == MODE_RECORDING) begin
      code = code ^ 8'($urandom_range(1, 255));
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 1;
      for (int k = 0; k < len && rec_mode == MODE_RECORDING; k++)
        send_word(OP_SAMPLE, raw_for_code(code), 1'b0, 1'b0, NO_WORD);
    end
    // samples after the finish are dropped; a start brings recording back
    repeat (3) send_word(OP_SAMPLE, 16'($urandom), 1'b0, 1'b0, NO_WORD);
    send_word(OP_START, 16'($urandom), 1'b0, 1'b0, NO_WORD);
    repeat (6) send_word(OP_SAMPLE, 16'($urandom), 1'b0, 1'b0, NO_WORD);
    in_valid <= 1'b0;

    // drain, then idle on to catch stray words
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/brlr_pkg.sv
rtl/core/brlr_keymap.sv
rtl/core/brlr_run.sv
rtl/core/button_run_length_recorder_top.sv
bench/testbench.sv
